[rtl/core/fhv_pkg.sv]
// Shared types and result codes for the floating-horizon visibility block.
`default_nettype none

package fhv_pkg;

  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned COLUMN_W = 10;

  typedef logic [1:0] vis_t;

  localparam vis_t VIS_NONE  = 2'd0;
  localparam vis_t VIS_ABOVE = 2'd1;
  localparam vis_t VIS_BELOW = 2'd2;

  // One column's horizon pair as held in the memory.
  typedef struct packed {
    logic signed [HEIGHT_W-1:0] upper;
    logic signed [HEIGHT_W-1:0] lower;
  } hword_t;

  // Outcome of testing one point against its column.
  typedef struct packed {
    vis_t   vis;
    logic   wr_en;
    hword_t word;
  } cls_res_t;

endpackage

`default_nettype wire

[rtl/core/fhv_hmem.sv]
// Horizon memory: one write port, one read port with registered read data.
`default_nettype none

module fhv_hmem
  import fhv_pkg::*;
#(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  hword_t        wr_data,
  input  logic          re,
  input  logic [AW-1:0] rd_addr,
  output hword_t        rd_data
);

  hword_t mem [DEPTH];
  hword_t rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/fhv_classify.sv]
// Point test against one column's horizons and the widened horizon pair.
`default_nettype none

module fhv_classify
  import fhv_pkg::*;
(
  input  hword_t                     cur,
  input  logic signed [HEIGHT_W-1:0] height,
  output cls_res_t                   res
);

  logic hidden;
  logic at_or_above;

  always_comb begin
    hidden      = (height < cur.upper) && (height > cur.lower);
    at_or_above = (height >= cur.upper);
    res.wr_en   = !hidden;
    res.vis     = hidden ? VIS_NONE : (at_or_above ? VIS_ABOVE : VIS_BELOW);
    // Widen both sides; a point can move either or both.
    res.word.upper = (height > cur.upper) ? height : cur.upper;
    res.word.lower = (height < cur.lower) ? height : cur.lower;
  end

endmodule

`default_nettype wire

[rtl/core/floating_horizon_visibility.sv]
// Top level of the floating-horizon visibility block.
// A point item is handled in two steps: a read of its column's horizon pair
// from the single-port-read memory, then the classification and write-back of
// the pair; the next item is accepted once the write-back is done. A point
// whose column is at or beyond COLUMNS is answered without touching the
// memory. A clear item sweeps the memory one column a cycle, and the next item
// waits until the sweep ends; the same sweep runs after reset, and no item is
// accepted until it ends. The result sits in an output register, and a new
// item is taken only when that register is empty or its result leaves in the
// same cycle, so a stalled receiver holds off the input.
`default_nettype none

module floating_horizon_visibility
  import fhv_pkg::*;
#(
  parameter int unsigned COLUMNS     = 1024,
  parameter int unsigned LOWER_START = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [COLUMN_W-1:0]        in_column,
  input  logic signed [HEIGHT_W-1:0] in_height,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 out_visibility,
  output logic [COLUMN_W-1:0]        out_column,
  output logic signed [HEIGHT_W-1:0] out_height
);

  localparam int unsigned AW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [12:0] COLS13 = 13'(COLUMNS);
  localparam logic [AW-1:0] LAST = AW'(COLUMNS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_TEST  = 3'b100
  } state_t;

  state_t                     state_r, state_nxt;
  logic [AW-1:0]              clr_cnt_r, clr_cnt_nxt;
  logic [COLUMN_W-1:0]        col_r, col_nxt;
  logic signed [HEIGHT_W-1:0] hgt_r, hgt_nxt;
  logic                       out_valid_r, out_valid_nxt;
  vis_t                       out_vis_r, out_vis_nxt;
  logic [COLUMN_W-1:0]        out_col_r, out_col_nxt;
  logic signed [HEIGHT_W-1:0] out_hgt_r, out_hgt_nxt;

  logic          accept;
  logic          in_range;
  logic          mem_we;
  logic [AW-1:0] mem_wr_addr;
  hword_t        mem_wr_data;
  logic          mem_re;
  hword_t        mem_rd_data;
  hword_t        clr_word;
  cls_res_t      cls;

  assign clr_word.upper = '0;
  assign clr_word.lower = HEIGHT_W'(LOWER_START);

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;
  assign in_range = ({3'b000, in_column} < COLS13);
  assign mem_re   = accept && in_kind && in_range;

  fhv_hmem #(
    .DEPTH(COLUMNS),
    .AW   (AW)
  ) u_hmem (
    .clk    (clk),
    .we     (mem_we),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .re     (mem_re),
    .rd_addr(AW'(in_column)),
    .rd_data(mem_rd_data)
  );

  fhv_classify u_classify (
    .cur   (mem_rd_data),
    .height(hgt_r),
    .res   (cls)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    col_nxt       = col_r;
    hgt_nxt       = hgt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_vis_nxt   = out_vis_r;
    out_col_nxt   = out_col_r;
    out_hgt_nxt   = out_hgt_r;
    mem_we        = 1'b0;
    mem_wr_addr   = clr_cnt_r;
    mem_wr_data   = clr_word;

    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          col_nxt = in_column;
          hgt_nxt = in_height;
          if (in_kind && in_range) begin
            state_nxt = ST_TEST;
          end else begin
            // Clear and out-of-range points answer at once.
            out_valid_nxt = 1'b1;
            out_vis_nxt   = VIS_NONE;
            out_col_nxt   = '0;
            out_hgt_nxt   = '0;
            if (!in_kind) begin
              state_nxt   = ST_CLEAR;
              clr_cnt_nxt = '0;
            end
          end
        end
      end
      ST_TEST: begin
        mem_we        = cls.wr_en;
        mem_wr_addr   = AW'(col_r);
        mem_wr_data   = cls.word;
        out_valid_nxt = 1'b1;
        out_vis_nxt   = cls.vis;
        out_col_nxt   = cls.wr_en ? col_r : '0;
        out_hgt_nxt   = cls.wr_en ? hgt_r : '0;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r     <= col_nxt;
    hgt_r     <= hgt_nxt;
    out_vis_r <= out_vis_nxt;
    out_col_r <= out_col_nxt;
    out_hgt_r <= out_hgt_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_visibility = out_vis_r;
  assign out_column     = out_col_r;
  assign out_height     = out_hgt_r;

  // The memory sweep and the point test must never admit a new item.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR || state_r == ST_TEST) |-> !in_ready)
    else $error("item admitted while the memory is busy");

  // A point test always leaves a result in the output register.
  a_test_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST) |=> out_valid_r)
    else $error("point test finished without a result");

  // The memory is written only by the sweep or a write-back.
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != ST_IDLE))
    else $error("memory written while idle");

  // A hidden point carries no column or height.
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_vis_r == VIS_NONE) |-> (out_col_r == '0 && out_hgt_r == '0))
    else $error("hidden result carries a payload");

  // A pending result is never overwritten before it is taken.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_vis_r)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Self-checking testbench for the floating-horizon visibility block.
`timescale 1ns / 1ps

import fhv_pkg::*;

class horizon_scoreboard;
  localparam int NCOL = 1024;
  localparam logic signed [15:0] LOWER_RESET = 16'sd1024;

  typedef struct {
    vis_t               vis;
    logic [9:0]         column;
    logic signed [15:0] height;
  } plot_t;

  logic signed [15:0] upper_h [NCOL];
  logic signed [15:0] lower_h [NCOL];
  plot_t              plot_q [$];
  int                 errors;

  function new();
    errors = 0;
    clear_horizons();
  endfunction

  function void clear_horizons();
    for (int i = 0; i < NCOL; i++) begin
      upper_h[i] = '0;
      lower_h[i] = LOWER_RESET;
    end
  endfunction

  // Classify one accepted item against its column and queue the plot it should give.
  function void note_input(logic kind, logic [9:0] col, logic signed [15:0] h);
    plot_t p;
    p.vis = VIS_NONE;
    p.column = '0;
    p.height = '0;
    if (!kind) begin
      clear_horizons();
    end else if (col < NCOL && !(h < upper_h[col] && h > lower_h[col])) begin
      p.vis = (h >= upper_h[col]) ? VIS_ABOVE : VIS_BELOW;
      p.column = col;
      p.height = h;
      // both horizons take in the height, whichever side it fell on
      if (h > upper_h[col]) upper_h[col] = h;
      if (h < lower_h[col]) lower_h[col] = h;
    end
    plot_q.push_back(p);
  endfunction

  task report(string what, int got, int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task check_result(vis_t vis, logic [9:0] col, logic signed [15:0] h);
    plot_t p;
    if (plot_q.size() == 0) begin
      report("result with no item waiting", vis, -1);
      return;
    end
    p = plot_q.pop_front();
    if (vis !== p.vis) report("visibility", vis, p.vis);
    if (col !== p.column) report("column", col, p.column);
    if (h !== p.height) report("height", h, p.height);
  endtask
endclass

module tb_top;
  localparam int IDLE_LIMIT  = 6000;
  localparam int PHASE_ITEMS = 375;
  localparam int LONG_HOLD   = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_kind;
  logic [COLUMN_W-1:0]        in_column;
  logic signed [HEIGHT_W-1:0] in_height;
  logic                       out_valid;
  logic                       out_ready;
  logic [1:0]                 out_visibility;
  logic [COLUMN_W-1:0]        out_column;
  logic signed [HEIGHT_W-1:0] out_height;

  horizon_scoreboard sb = new();

  int send_idle   = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;
  int quiet_count = 0;

  floating_horizon_visibility DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_column      (in_column),
    .in_height      (in_height),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_visibility (out_visibility),
    .out_column     (out_column),
    .out_height     (out_height)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Offer one item, idling first at the current rate, and hold it until taken.
  task automatic send_item(input logic kind, input logic [9:0] col,
                           input logic signed [15:0] h);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_column <= col;
    in_height <= h;
    do @(posedge clk); while (!in_ready);
    sb.note_input(kind, col, h);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.plot_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: check each taken result, then pick out_ready for the next edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready)
        sb.check_result(out_visibility, out_column, out_height);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int         idle_tab [4];
    int         stall_tab [4];
    int         sel;
    int         hv;
    logic       kind;
    logic [9:0] col;

    idle_tab  = '{0, 70, 0, 12};
    stall_tab = '{0, 0, 70, 12};
    in_valid  = 1'b0;
    in_kind   = 1'b0;
    in_column = '0;
    in_height = '0;
    rst_n     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: fresh horizons, repeats on a flat column, extremes, clear, bit patterns.
    send_item(1'b1, 10'd0, 16'sd0);
    send_item(1'b1, 10'd0, 16'sd0);
    send_item(1'b1, 10'd1, 16'sd32767);
    send_item(1'b1, 10'd1, -16'sd32768);
    send_item(1'b1, 10'd1, 16'sd100);
    send_item(1'b1, 10'd1, 16'sd32767);
    send_item(1'b1, 10'd1, 16'sd32766);
    send_item(1'b1, 10'd1023, 16'sd1024);
    send_item(1'b1, 10'd1023, 16'sd1023);
    send_item(1'b1, 10'd1023, 16'sd1024);
    send_item(1'b1, 10'd512, -16'sd1);
    send_item(1'b1, 10'd512, 16'sd0);
    send_item(1'b0, 10'd1023, -16'sd32768);
    send_item(1'b1, 10'd1, 16'sd100);
    send_item(1'b1, 10'h2AA, 16'sh5555);
    send_item(1'b1, 10'h155, 16'shAAAA);
    send_item(1'b1, 10'h2AA, 16'sh0001);
    send_item(1'b0, 10'h155, 16'sh7FFF);
    send_item(1'b1, 10'h2AA, 16'sh0001);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      send_idle = idle_tab[p];
      stall_pct = stall_tab[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the receiver off while items keep coming, so the block backs up
        if (p == 0 && n == 60) hold_cycles = LONG_HOLD;
        kind = ($urandom_range(79) != 0);
        if ($urandom_range(9) < 6) col = 10'($urandom_range(15));
        else col = 10'($urandom_range(1023));
        sel = $urandom_range(99);
        if (sel < 25) hv = int'($urandom_range(65535)) - 32768;
        else if (sel < 50) hv = int'($urandom_range(3000)) - 1500;
        else if (sel < 70) hv = int'(sb.upper_h[col]) + int'($urandom_range(4)) - 2;
        else if (sel < 90) hv = int'(sb.lower_h[col]) + int'($urandom_range(4)) - 2;
        else begin
          case ($urandom_range(5))
            0: hv = -32768;
            1: hv = 32767;
            2: hv = 0;
            3: hv = -1;
            4: hv = 1023;
            default: hv = 1024;
          endcase
        end
        if (hv > 32767) hv = 32767;
        if (hv < -32768) hv = -32768;
        send_item(kind, col, 16'(hv));
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.plot_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
